FILE: hdl/ctgi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctgi_pkg
// Shared types and constants for the calibration table gap interpolator:
// command codes, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
package ctgi_pkg;

  // Default configuration
  localparam int DEF_NUM_SENSORS = 4;
  localparam int DEF_KEY_BITS    = 10;
  localparam int DEF_VALUE_BITS  = 16;

  // Fixed port field widths
  localparam int CMD_W    = 2;
  localparam int SENSOR_W = 2;
  localparam int RAW_KEY_W = 10;
  localparam int DATA_W   = 16;

  // Request command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_ZERO   = 2'd2,
    CMD_INTERP = 2'd3
  } cmd_t;

  // Controller states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_RWAIT,
    S_ZERO,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DIV,
    S_FILL_INIT,
    S_FILL,
    S_DONE
  } state_t;

  // Write address/data source
  typedef enum logic [1:0] {
    WSRC_IDX,    // zero at scan index (clear / zero sweep)
    WSRC_KEY,    // request value at request key
    WSRC_FILL    // interpolated value at fill index
  } wsrc_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic  accept;       // capture request, clear scan state
    logic  mem_we;
    wsrc_t wsrc;
    logic  raddr_key;    // read at request key instead of scan index
    logic  ld_result;
    logic  idx_inc;
    logic  sel_inc;
    logic  anchor_ld;
    logic  anchor_next;  // anchor value from latched next entry
    logic  div_start;
    logic  div_step;
    logic  fill_init;
    logic  fill_step;
  } ctl_t;

  // Datapath -> controller status
  typedef struct packed {
    cmd_t cmd;
    logic sens_ok;
    logic idx_last;
    logic sel_last;
    logic rd_nonzero;
    logic gap_ok;
    logic div_last;
    logic fill_last;
  } sts_t;

endpackage : ctgi_pkg
`default_nettype wire

FILE: hdl/calibration_table_gap_interpolator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// calibration_table_gap_interpolator
// Per-sensor signed calibration tables with write, read, zero and linear
// gap-fill interpolation of zero runs between nonzero anchors.
//
//   Channel  Ports                                         Handshake
//   input    in_command in_sensor in_raw_key in_new_value  start / busy
//   result   out_done_command out_read_value               out_strobe
//
// Write passes through EXEC to DONE, read through EXEC, RWAIT and DONE;
// zero sweeps the 2^KEY_BITS entries of the chosen table. Interpolate scans
// each entry through the single read port, runs a bit-serial divider per
// gap and writes each filled entry. After reset the store is cleared one entry
// per cycle, NUM_SENSORS * 2^KEY_BITS entries, with busy high. One request is
// in flight at a time; the strobe lasts one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module calibration_table_gap_interpolator
  import ctgi_pkg::*;
#(
  parameter int NUM_SENSORS = DEF_NUM_SENSORS,
  parameter int KEY_BITS    = DEF_KEY_BITS,
  parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [CMD_W-1:0]         in_command,
  input  wire logic [SENSOR_W-1:0]      in_sensor,
  input  wire logic [RAW_KEY_W-1:0]     in_raw_key,
  input  wire logic signed [DATA_W-1:0] in_new_value,
  output logic                          out_strobe,
  output logic [CMD_W-1:0]              out_done_command,
  output logic signed [DATA_W-1:0]      out_read_value
);

  ctl_t ctl;
  sts_t sts;

  // Controller
  ctgi_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy),
    .done  (out_strobe)
  );

  // Datapath
  ctgi_dp #(
    .NUM_SENSORS (NUM_SENSORS),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .sts              (sts),
    .in_command       (in_command),
    .in_sensor        (in_sensor),
    .in_raw_key       (in_raw_key),
    .in_new_value     (in_new_value),
    .out_done_command (out_done_command),
    .out_read_value   (out_read_value)
  );

endmodule : calibration_table_gap_interpolator
`default_nettype wire

FILE: hdl/ctgi_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctgi_ctrl
// Controller FSM: sequences the reset clear sweep, single-entry requests,
// table zeroing and the interpolation scan / divide / fill loop.
// ----------------------------------------------------------------------------
module ctgi_ctrl
  import ctgi_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire sts_t sts,
  output ctl_t      ctl,
  output logic      busy,
  output logic      done
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (sts.idx_last && sts.sel_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (!sts.sens_ok) begin
          state_nxt = S_DONE;
        end else begin
          case (sts.cmd)
            CMD_WRITE:  state_nxt = S_DONE;
            CMD_READ:   state_nxt = S_RWAIT;
            CMD_ZERO:   state_nxt = S_ZERO;
            CMD_INTERP: state_nxt = S_SCAN_RD;
            default:    state_nxt = S_DONE;
          endcase
        end
      end
      S_RWAIT:   state_nxt = S_DONE;
      S_ZERO: begin
        if (sts.idx_last) state_nxt = S_DONE;
      end
      S_SCAN_RD: state_nxt = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (sts.rd_nonzero && sts.gap_ok) state_nxt = S_DIV;
        else if (sts.idx_last)            state_nxt = S_DONE;
        else                              state_nxt = S_SCAN_RD;
      end
      S_DIV: begin
        if (sts.div_last) state_nxt = S_FILL_INIT;
      end
      S_FILL_INIT: state_nxt = S_FILL;
      S_FILL: begin
        if (sts.fill_last) state_nxt = sts.idx_last ? S_DONE : S_SCAN_RD;
      end
      S_DONE:    state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctl      = '0;
    ctl.wsrc = WSRC_IDX;
    busy     = (state_r != S_IDLE);
    done     = 1'b0;
    case (state_r)
      S_CLEAR: begin
        ctl.mem_we  = 1'b1;
        ctl.idx_inc = 1'b1;
        ctl.sel_inc = sts.idx_last;
      end
      S_IDLE: begin
        ctl.accept = start;
      end
      S_EXEC: begin
        if (sts.sens_ok) begin
          case (sts.cmd)
            CMD_WRITE: begin
              ctl.mem_we = 1'b1;
              ctl.wsrc   = WSRC_KEY;
            end
            CMD_READ:  ctl.raddr_key = 1'b1;
            default:   ctl.raddr_key = 1'b0;
          endcase
        end
      end
      S_RWAIT: begin
        ctl.ld_result = 1'b1;
      end
      S_ZERO: begin
        ctl.mem_we  = 1'b1;
        ctl.idx_inc = 1'b1;
      end
      S_SCAN_CHK: begin
        if (sts.rd_nonzero && sts.gap_ok) begin
          ctl.div_start = 1'b1;
        end else begin
          ctl.anchor_ld = sts.rd_nonzero;
          ctl.idx_inc   = 1'b1;
        end
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
      end
      S_FILL_INIT: begin
        ctl.fill_init = 1'b1;
      end
      S_FILL: begin
        ctl.mem_we    = 1'b1;
        ctl.wsrc      = WSRC_FILL;
        ctl.fill_step = 1'b1;
        if (sts.fill_last) begin
          ctl.anchor_ld   = 1'b1;
          ctl.anchor_next = 1'b1;
          ctl.idx_inc     = 1'b1;
        end
      end
      S_DONE: begin
        done = 1'b1;
      end
      default: begin
        done = 1'b0;
      end
    endcase
  end

endmodule : ctgi_ctrl
`default_nettype wire

FILE: hdl/ctgi_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctgi_dp
// Datapath: calibration store, request registers, scan counters, the
// restoring divider for a gap's step size and the incremental fill unit.
// ----------------------------------------------------------------------------
module ctgi_dp
  import ctgi_pkg::*;
#(
  parameter int NUM_SENSORS = DEF_NUM_SENSORS,
  parameter int KEY_BITS    = DEF_KEY_BITS,
  parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ctl_t                  ctl,
  output sts_t                       sts,
  input  wire logic [CMD_W-1:0]      in_command,
  input  wire logic [SENSOR_W-1:0]   in_sensor,
  input  wire logic [RAW_KEY_W-1:0]  in_raw_key,
  input  wire logic signed [DATA_W-1:0] in_new_value,
  output logic [CMD_W-1:0]           out_done_command,
  output logic signed [DATA_W-1:0]   out_read_value
);

  localparam int KB     = KEY_BITS;
  localparam int VB     = VALUE_BITS;
  localparam int SENS_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int DEPTH  = NUM_SENSORS << KEY_BITS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int DW     = VB + 1;            // divider dividend width
  localparam int CNT_W  = $clog2(DW + 1);

  // Request registers
  cmd_t                cmd_r;
  logic [SENS_W-1:0]   sel_r;
  logic [KB-1:0]       key_r;
  logic signed [DATA_W-1:0] val_r;
  logic                sens_ok_r;
  logic signed [DATA_W-1:0] result_r;

  // Scan / anchor state
  logic [KB-1:0]       idx_r;
  logic [KB-1:0]       prev_r;
  logic                have_prev_r;
  logic signed [VB-1:0] last_r;
  logic signed [VB-1:0] next_r;
  logic [KB-1:0]       span_r;
  logic                neg_r;

  // Divider
  logic [DW-1:0]       quot_r;
  logic [KB:0]         rem_r;
  logic [CNT_W-1:0]    cnt_r;

  // Fill unit
  logic [KB-1:0]       fidx_r;
  logic [DW-1:0]       q_r;
  logic [KB-1:0]       r_r;

  // Memory
  logic signed [VB-1:0] mem [DEPTH];
  logic signed [VB-1:0] rd_data_r;
  logic [ADDR_W-1:0]   waddr;
  logic [ADDR_W-1:0]   raddr;
  logic signed [VB-1:0] wdata;

  // Combinational helpers
  logic [KB-1:0]        gap;
  logic signed [VB:0]   diff;
  logic [DW-1:0]        diff_mag;
  logic [KB:0]          rem_sh;
  logic                 rem_ge;
  logic [KB:0]          rem_nxt;
  logic [DW-1:0]        quot_nxt;
  logic [KB:0]          r_sum;
  logic                 r_wrap;
  logic [KB-1:0]        r_nxt;
  logic [DW-1:0]        q_nxt;
  logic signed [VB+1:0] q_signed;
  logic signed [VB+1:0] fill_sum;

  // Gap to previous anchor and signed step
  assign gap      = idx_r - prev_r;
  assign diff     = (VB+1)'(rd_data_r) - (VB+1)'(last_r);
  assign diff_mag = diff[VB] ? DW'(-diff) : DW'(diff);

  // Restoring divide step: one quotient bit a cycle
  assign rem_sh   = {rem_r[KB-1:0], quot_r[DW-1]};
  assign rem_ge   = (rem_sh >= {1'b0, span_r});
  assign rem_nxt  = rem_ge ? (rem_sh - {1'b0, span_r}) : rem_sh;
  assign quot_nxt = {quot_r[DW-2:0], rem_ge};

  // Incremental quotient of |diff|*k/span: add step quotient and remainder
  assign r_sum  = {1'b0, r_r} + rem_r;
  assign r_wrap = (r_sum >= {1'b0, span_r});
  assign r_nxt  = r_wrap ? KB'(r_sum - {1'b0, span_r}) : KB'(r_sum);
  assign q_nxt  = q_r + quot_r + DW'(r_wrap);

  // Filled entry: last + sign * q
  assign q_signed = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
  assign fill_sum = (VB+2)'(last_r) + q_signed;

  // Write port select
  always_comb begin
    case (ctl.wsrc)
      WSRC_KEY: begin
        waddr = ADDR_W'({sel_r, key_r});
        wdata = VB'(val_r);
      end
      WSRC_FILL: begin
        waddr = ADDR_W'({sel_r, fidx_r});
        wdata = VB'(fill_sum);
      end
      default: begin
        waddr = ADDR_W'({sel_r, idx_r});
        wdata = '0;
      end
    endcase
  end

  assign raddr = ctl.raddr_key ? ADDR_W'({sel_r, key_r}) : ADDR_W'({sel_r, idx_r});

  // Calibration store, registered read
  always_ff @(posedge clk) begin
    if (ctl.mem_we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  // Sweep counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      sel_r <= '0;
    end else begin
      if (ctl.accept) begin
        idx_r <= '0;
        sel_r <= SENS_W'(in_sensor);
      end else begin
        if (ctl.idx_inc) idx_r <= idx_r + KB'(1);
        if (ctl.sel_inc) sel_r <= sel_r + SENS_W'(1);
      end
    end
  end

  // Request capture and result
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_r     <= cmd_t'(in_command);
      key_r     <= KB'(in_raw_key);
      val_r     <= in_new_value;
      sens_ok_r <= (int'(in_sensor) < NUM_SENSORS);
      result_r  <= '0;
    end else if (ctl.ld_result) begin
      result_r  <= DATA_W'(rd_data_r);
    end
  end

  // Anchors and gap setup
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      have_prev_r <= 1'b0;
    end else if (ctl.anchor_ld) begin
      have_prev_r <= 1'b1;
      prev_r      <= idx_r;
      last_r      <= ctl.anchor_next ? next_r : rd_data_r;
    end
    if (ctl.div_start) begin
      next_r <= rd_data_r;
      span_r <= gap;
      neg_r  <= diff[VB];
    end
  end

  // Divider |diff| / span
  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      quot_r <= diff_mag;
      rem_r  <= '0;
      cnt_r  <= CNT_W'(DW);
    end else if (ctl.div_step) begin
      quot_r <= quot_nxt;
      rem_r  <= rem_nxt;
      cnt_r  <= cnt_r - CNT_W'(1);
    end
  end

  // Fill unit
  always_ff @(posedge clk) begin
    if (ctl.fill_init) begin
      q_r    <= quot_r;
      r_r    <= KB'(rem_r);
      fidx_r <= prev_r + KB'(1);
    end else if (ctl.fill_step) begin
      q_r    <= q_nxt;
      r_r    <= r_nxt;
      fidx_r <= fidx_r + KB'(1);
    end
  end

  // Status to controller
  assign sts.cmd        = cmd_r;
  assign sts.sens_ok    = sens_ok_r;
  assign sts.idx_last   = (idx_r == {KB{1'b1}});
  assign sts.sel_last   = (sel_r == SENS_W'(NUM_SENSORS - 1));
  assign sts.rd_nonzero = (rd_data_r != '0);
  assign sts.gap_ok     = have_prev_r && (gap > KB'(1));
  assign sts.div_last   = (cnt_r == CNT_W'(1));
  assign sts.fill_last  = ((fidx_r + KB'(1)) == idx_r);

  assign out_done_command = cmd_r;
  assign out_read_value   = result_r;

endmodule : ctgi_dp
`default_nettype wire
